@@ rtl/core/pfe_pkg.sv @@
// ----------------------------------------------------------------------------
// pfe_pkg: shared types and constants
// Widths, fixed-point constants, CORDIC arctangent table and the structs
// passed between the sequencer, the multiplier and the CORDIC unit.
// ----------------------------------------------------------------------------
package pfe_pkg;

  localparam int POS_WIDTH_DEF = 24;
  localparam int OUT_WIDTH_DEF = 48;

  localparam int Q_FRAC    = 21;
  localparam int Q_WIDTH   = 24;
  localparam int MAG_WIDTH = 24;

  localparam int LIMB_W  = 16;
  localparam int MUL_A_W = 3 * LIMB_W;
  localparam int MUL_B_W = 32;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int PP_W    = LIMB_W + 1 + MUL_B_W;

  localparam int RES_W = 48;
  localparam int SUM_W = 52;

  localparam int CORDIC_STEPS = 18;
  localparam int STEP_W       = 5;
  localparam int CV_W         = 33;
  localparam int ANG_W        = 34;

  localparam logic signed [CV_W-1:0]    CORDIC_GAIN_Q30 = 33'sd652032874;
  localparam logic signed [MUL_B_W-1:0] TEN_PI_Q24      = 32'sd527071785;

  typedef struct packed {
    logic                      start;
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic signed [CV_W-1:0] cx;
    logic signed [CV_W-1:0] sx;
    logic signed [CV_W-1:0] cy;
    logic signed [CV_W-1:0] sy;
  } trig_t;

  function automatic logic [ANG_W-1:0] turn_atan(input logic [STEP_W-1:0] idx);
    logic [ANG_W-1:0] v;
    case (idx)
      5'd0:    v = 34'd536870912;
      5'd1:    v = 34'd316933406;
      5'd2:    v = 34'd167458907;
      5'd3:    v = 34'd85004756;
      5'd4:    v = 34'd42667331;
      5'd5:    v = 34'd21354465;
      5'd6:    v = 34'd10679838;
      5'd7:    v = 34'd5340245;
      5'd8:    v = 34'd2670163;
      5'd9:    v = 34'd1335087;
      5'd10:   v = 34'd667544;
      5'd11:   v = 34'd333772;
      5'd12:   v = 34'd166886;
      5'd13:   v = 34'd83443;
      5'd14:   v = 34'd41721;
      5'd15:   v = 34'd20860;
      5'd16:   v = 34'd10430;
      5'd17:   v = 34'd5215;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/core/pfe_if.sv @@
// ----------------------------------------------------------------------------
// pfe_if: stream channels
// Valid/ready channels for particle positions and force/energy results.
// ----------------------------------------------------------------------------
interface pfe_in_if #(
  parameter int POS_WIDTH = pfe_pkg::POS_WIDTH_DEF
) ();
  logic                        valid;
  logic                        ready;
  logic signed [POS_WIDTH-1:0] x_pos;
  logic signed [POS_WIDTH-1:0] y_pos;
  logic                        last_particle;

  modport source (output valid, output x_pos, output y_pos, output last_particle,
                  input ready);
  modport sink   (input valid, input x_pos, input y_pos, input last_particle,
                  output ready);
endinterface

interface pfe_out_if #(
  parameter int OUT_WIDTH = pfe_pkg::OUT_WIDTH_DEF
) ();
  logic                        valid;
  logic                        ready;
  logic signed [OUT_WIDTH-1:0] force_x;
  logic signed [OUT_WIDTH-1:0] force_y;
  logic signed [OUT_WIDTH-1:0] particle_energy;
  logic signed [OUT_WIDTH-1:0] total_energy;
  logic                        frame_done;

  modport source (output valid, output force_x, output force_y,
                  output particle_energy, output total_energy, output frame_done,
                  input ready);
  modport sink   (input valid, input force_x, input force_y,
                  input particle_energy, input total_energy, input frame_done,
                  output ready);
endinterface

@@ rtl/core/pfe_mul.sv @@
// ----------------------------------------------------------------------------
// pfe_mul: limb-serial multiplier
// Signed 48 x 32 multiply, one 16-bit limb of the first operand per cycle.
// ----------------------------------------------------------------------------
module pfe_mul (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pfe_pkg::mul_req_t                 req_i,
  output logic                              done_o,
  output logic signed [pfe_pkg::MUL_P_W-1:0] p_o
);
  import pfe_pkg::*;

  logic signed [MUL_A_W-1:0] a_q;
  logic signed [MUL_B_W-1:0] b_q;
  logic signed [MUL_P_W-1:0] p_q;
  logic [1:0]                cnt_q;
  logic                      busy_q;
  logic                      done_q;

  logic signed [LIMB_W:0]    limb;
  logic signed [PP_W-1:0]    pp;
  logic signed [MUL_P_W-1:0] pp_ext;
  logic signed [MUL_P_W-1:0] pp_sh;

  always_comb begin
    case (cnt_q)
      2'd0:    limb = $signed({1'b0, a_q[LIMB_W-1:0]});
      2'd1:    limb = $signed({1'b0, a_q[2*LIMB_W-1:LIMB_W]});
      default: limb = $signed({a_q[MUL_A_W-1], a_q[MUL_A_W-1:2*LIMB_W]});
    endcase
    pp     = limb * b_q;
    pp_ext = MUL_P_W'(pp);
    case (cnt_q)
      2'd0:    pp_sh = pp_ext;
      2'd1:    pp_sh = pp_ext <<< LIMB_W;
      default: pp_sh = pp_ext <<< (2 * LIMB_W);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == 2'd2) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      a_q <= req_i.a;
      b_q <= req_i.b;
      p_q <= '0;
    end else if (busy_q) begin
      p_q <= p_q + pp_sh;
    end
  end

  assign done_o = done_q;
  assign p_o    = p_q;

endmodule

@@ rtl/core/pfe_cordic.sv @@
// ----------------------------------------------------------------------------
// pfe_cordic: iterative CORDIC
// Cosine and sine of the x phase, then of the y phase, one rotation a cycle.
// ----------------------------------------------------------------------------
module pfe_cordic (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [pfe_pkg::Q_FRAC-1:0]  phase_x_i,
  input  logic [pfe_pkg::Q_FRAC-1:0]  phase_y_i,
  output pfe_pkg::trig_t              trig_o,
  output logic                        valid_o
);
  import pfe_pkg::*;

  typedef enum logic {
    C_IDLE,
    C_RUN
  } cstate_e;

  localparam logic signed [ANG_W-1:0] QUARTER = 34'sh040000000;
  localparam logic signed [ANG_W-1:0] HALF    = 34'sh080000000;

  cstate_e                 state_q;
  logic                    sel_q;
  logic [STEP_W-1:0]       step_q;
  logic                    valid_q;
  logic                    neg_q;
  logic signed [CV_W-1:0]  cr_q, sr_q;
  logic signed [ANG_W-1:0] ang_q;
  logic [Q_FRAC-1:0]       phy_q;
  trig_t                   trig_q;

  logic signed [CV_W-1:0]  cr_d, sr_d, dc, ds;
  logic signed [ANG_W-1:0] ang_d, atan;
  logic signed [ANG_W-1:0] ld_ang;
  logic                    ld_neg;
  logic [Q_FRAC-1:0]       ld_phase;

  always_comb begin
    logic signed [ANG_W-1:0] raw;
    ld_phase = (state_q == C_IDLE) ? phase_x_i : phy_q;
    raw      = ANG_W'($signed({ld_phase, {(32 - Q_FRAC){1'b0}}}));
    ld_neg   = (raw > QUARTER) || (raw < -QUARTER);
    if (!ld_neg) begin
      ld_ang = raw;
    end else if (raw > 0) begin
      ld_ang = raw - HALF;
    end else begin
      ld_ang = raw + HALF;
    end
  end

  always_comb begin
    dc   = sr_q >>> step_q;
    ds   = cr_q >>> step_q;
    atan = $signed(turn_atan(step_q));
    if (!ang_q[ANG_W-1]) begin
      cr_d  = cr_q - dc;
      sr_d  = sr_q + ds;
      ang_d = ang_q - atan;
    end else begin
      cr_d  = cr_q + dc;
      sr_d  = sr_q - ds;
      ang_d = ang_q + atan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      sel_q   <= 1'b0;
      step_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      case (state_q)
        C_IDLE: begin
          if (start_i) begin
            state_q <= C_RUN;
            sel_q   <= 1'b0;
            step_q  <= '0;
            valid_q <= 1'b0;
          end
        end
        C_RUN: begin
          if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
            step_q <= '0;
            if (sel_q) begin
              state_q <= C_IDLE;
              valid_q <= 1'b1;
            end else begin
              sel_q <= 1'b1;
            end
          end else begin
            step_q <= step_q + STEP_W'(1);
          end
        end
        default: state_q <= C_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == C_IDLE && start_i) begin
      phy_q <= phase_y_i;
      ang_q <= ld_ang;
      neg_q <= ld_neg;
      cr_q  <= CORDIC_GAIN_Q30;
      sr_q  <= '0;
    end else if (state_q == C_RUN) begin
      if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
        if (sel_q) begin
          trig_q.cy <= neg_q ? -cr_d : cr_d;
          trig_q.sy <= neg_q ? -sr_d : sr_d;
        end else begin
          trig_q.cx <= neg_q ? -cr_d : cr_d;
          trig_q.sx <= neg_q ? -sr_d : sr_d;
          ang_q     <= ld_ang;
          neg_q     <= ld_neg;
          cr_q      <= CORDIC_GAIN_Q30;
          sr_q      <= '0;
        end
      end else begin
        cr_q  <= cr_d;
        sr_q  <= sr_d;
        ang_q <= ang_d;
      end
    end
  end

  assign trig_o  = trig_q;
  assign valid_o = valid_q;

endmodule

@@ rtl/core/test_potential_force_energy.sv @@
// ----------------------------------------------------------------------------
// test_potential_force_energy: test potential force and energy evaluator
// Per particle: U = 10(x^10+y^10) + 5 sin(2pi x)cos(2pi y), forces -dU/dx,
// -dU/dy, and a saturating frame energy sum cleared after the last particle.
// ----------------------------------------------------------------------------
// For each particle, a sequencer issues 28 operations to one limb-serial
// multiplier (each one issued, multiplied limb by limb and written back),
// covering both power chains, the trig products and the constant scalings,
// and a finish state folds the terms into the output register. The CORDIC
// unit (x phase, then y phase) runs alongside the power chains. The input
// is not ready while a particle is in work, so a new particle is taken only
// after the last one has finished; a finished result waits in the output
// register while the next particle is taken, and the next result holds
// until that register is free.
module test_potential_force_energy #(
  parameter int POS_WIDTH = pfe_pkg::POS_WIDTH_DEF,
  parameter int OUT_WIDTH = pfe_pkg::OUT_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pfe_in_if.sink    in_i,
  pfe_out_if.source out_o
);
  import pfe_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_WAIT,
    S_FINISH
  } state_e;

  typedef enum logic [3:0] {
    D_ACC_X,
    D_ACC_Y,
    D_F9X,
    D_E10X,
    D_F9Y,
    D_E10Y,
    D_T,
    D_ETRIG,
    D_FXT,
    D_FYT
  } dst_e;

  localparam logic [4:0] OP_F9X     = 5'd8;
  localparam logic [4:0] OP_E10X    = 5'd10;
  localparam logic [4:0] OP_POW_Y0  = 5'd11;
  localparam logic [4:0] OP_F9Y     = 5'd19;
  localparam logic [4:0] OP_E10Y    = 5'd21;
  localparam logic [4:0] OP_T_E     = 5'd22;
  localparam logic [4:0] OP_E_TRIG  = 5'd23;
  localparam logic [4:0] OP_T_FX    = 5'd24;
  localparam logic [4:0] OP_FX_TRIG = 5'd25;
  localparam logic [4:0] OP_T_FY    = 5'd26;
  localparam logic [4:0] OP_FY_TRIG = 5'd27;

  localparam logic [5:0] RND_POW   = 6'd21;
  localparam logic [5:0] RND_SCALE = 6'd5;
  localparam logic [5:0] RND_PROD  = 6'd30;
  localparam logic [5:0] RND_E     = 6'd14;
  localparam logic [5:0] RND_F     = 6'd38;

  localparam int EW = ((SUM_W > OUT_WIDTH) ? SUM_W : OUT_WIDTH) + 1;
  localparam logic signed [EW-1:0] OUT_MAX =
    $signed({{(EW - OUT_WIDTH + 1){1'b0}}, {(OUT_WIDTH - 1){1'b1}}});
  localparam logic signed [EW-1:0] OUT_MIN = ~OUT_MAX;

  function automatic logic signed [OUT_WIDTH-1:0] sat_out(input logic signed [EW-1:0] v);
    logic signed [EW-1:0] c;
    c = (v > OUT_MAX) ? OUT_MAX : ((v < OUT_MIN) ? OUT_MIN : v);
    return c[OUT_WIDTH-1:0];
  endfunction

  state_e                   state_q;
  logic [4:0]               op_q;
  logic                     last_q;
  logic                     negx_q, negy_q;
  logic [MAG_WIDTH-1:0]     magx_q, magy_q;
  logic signed [RES_W-1:0]  accx_q, accy_q, f9x_q, e10x_q, f9y_q, e10y_q;
  logic signed [RES_W-1:0]  t_q, etrig_q, fxt_q, fyt_q;
  logic signed [OUT_WIDTH-1:0] energy_sum_q;
  logic                     out_valid_q;
  logic signed [OUT_WIDTH-1:0] fx_q, fy_q, pe_q, te_q;
  logic                     fd_q;

  logic signed [Q_WIDTH-1:0] px, py;
  logic signed [Q_WIDTH:0]   px_neg, py_neg;
  logic                      in_acc;
  logic                      out_free;
  mul_req_t                  mreq;
  logic                      mdone;
  logic signed [MUL_P_W-1:0] mp;
  trig_t                     trig;
  logic                      trig_valid;

  logic signed [MUL_A_W-1:0] op_a;
  logic signed [MUL_B_W-1:0] op_b;
  logic [5:0]                op_k;
  dst_e                      op_dst;
  logic signed [MUL_P_W-1:0] rsum, rres;
  logic signed [RES_W-1:0]   res;

  logic signed [OUT_WIDTH-1:0] energy, total, fx, fy;
  logic signed [EW-1:0]        e_raw;

  if (POS_WIDTH >= Q_WIDTH) begin : g_narrow
    assign px = Q_WIDTH'(in_i.x_pos >>> (POS_WIDTH - Q_WIDTH));
    assign py = Q_WIDTH'(in_i.y_pos >>> (POS_WIDTH - Q_WIDTH));
  end else begin : g_widen
    assign px = $signed({in_i.x_pos, {(Q_WIDTH - POS_WIDTH){1'b0}}});
    assign py = $signed({in_i.y_pos, {(Q_WIDTH - POS_WIDTH){1'b0}}});
  end

  assign px_neg   = -(Q_WIDTH + 1)'(px);
  assign py_neg   = -(Q_WIDTH + 1)'(py);
  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    op_a   = MUL_A_W'(accx_q);
    op_b   = MUL_B_W'(magx_q);
    op_k   = RND_POW;
    op_dst = D_ACC_X;
    case (op_q)
      OP_F9X: begin
        op_b = 32'sd100; op_k = RND_SCALE; op_dst = D_F9X;
      end
      OP_E10X: begin
        op_b = 32'sd10; op_k = RND_SCALE; op_dst = D_E10X;
      end
      OP_F9Y: begin
        op_a = MUL_A_W'(accy_q); op_b = 32'sd100; op_k = RND_SCALE; op_dst = D_F9Y;
      end
      OP_E10Y: begin
        op_a = MUL_A_W'(accy_q); op_b = 32'sd10; op_k = RND_SCALE; op_dst = D_E10Y;
      end
      OP_T_E: begin
        op_a = MUL_A_W'(trig.sx); op_b = MUL_B_W'(trig.cy); op_k = RND_PROD;
        op_dst = D_T;
      end
      OP_E_TRIG: begin
        op_a = MUL_A_W'(t_q); op_b = 32'sd5; op_k = RND_E; op_dst = D_ETRIG;
      end
      OP_T_FX: begin
        op_a = MUL_A_W'(trig.cx); op_b = MUL_B_W'(trig.cy); op_k = RND_PROD;
        op_dst = D_T;
      end
      OP_FX_TRIG: begin
        op_a = MUL_A_W'(t_q); op_b = TEN_PI_Q24; op_k = RND_F; op_dst = D_FXT;
      end
      OP_T_FY: begin
        op_a = MUL_A_W'(trig.sx); op_b = MUL_B_W'(trig.sy); op_k = RND_PROD;
        op_dst = D_T;
      end
      OP_FY_TRIG: begin
        op_a = MUL_A_W'(t_q); op_b = TEN_PI_Q24; op_k = RND_F; op_dst = D_FYT;
      end
      default: begin
        if (op_q >= OP_POW_Y0) begin
          op_a = MUL_A_W'(accy_q); op_b = MUL_B_W'(magy_q); op_dst = D_ACC_Y;
        end
      end
    endcase
  end

  assign rsum = mp + $signed(MUL_P_W'(1) << (op_k - 6'd1));
  assign rres = rsum >>> op_k;
  assign res  = rres[RES_W-1:0];

  assign mreq.start = (state_q == S_ISSUE) && ((op_q < OP_T_E) || trig_valid);
  assign mreq.a     = op_a;
  assign mreq.b     = op_b;

  pfe_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .done_o (mdone),
    .p_o    (mp)
  );

  pfe_cordic u_cordic (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (in_acc),
    .phase_x_i (px[Q_FRAC-1:0]),
    .phase_y_i (py[Q_FRAC-1:0]),
    .trig_o    (trig),
    .valid_o   (trig_valid)
  );

  always_comb begin
    logic signed [RES_W-1:0] fxp, fyp;
    fxp    = negx_q ? -f9x_q : f9x_q;
    fyp    = negy_q ? -f9y_q : f9y_q;
    e_raw  = EW'(e10x_q) + EW'(e10y_q) + EW'(etrig_q);
    energy = sat_out(e_raw);
    total  = sat_out(EW'(energy_sum_q) + EW'(energy));
    fx     = sat_out(-(EW'(fxp) + EW'(fxt_q)));
    fy     = sat_out(EW'(fyt_q) - EW'(fyp));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      op_q         <= '0;
      out_valid_q  <= 1'b0;
      energy_sum_q <= '0;
    end else begin
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            state_q <= S_ISSUE;
            op_q    <= '0;
          end
        end
        S_ISSUE: begin
          if (mreq.start) begin
            state_q <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (mdone) begin
            if (op_q == OP_FY_TRIG) begin
              state_q <= S_FINISH;
            end else begin
              state_q <= S_ISSUE;
              op_q    <= op_q + 5'd1;
            end
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state_q      <= S_IDLE;
            out_valid_q  <= 1'b1;
            energy_sum_q <= last_q ? '0 : total;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      last_q <= in_i.last_particle;
      negx_q <= px[Q_WIDTH-1];
      negy_q <= py[Q_WIDTH-1];
      magx_q <= px[Q_WIDTH-1] ? px_neg[MAG_WIDTH-1:0] : MAG_WIDTH'(px);
      magy_q <= py[Q_WIDTH-1] ? py_neg[MAG_WIDTH-1:0] : MAG_WIDTH'(py);
      accx_q <= RES_W'(px[Q_WIDTH-1] ? px_neg[MAG_WIDTH-1:0] : MAG_WIDTH'(px));
      accy_q <= RES_W'(py[Q_WIDTH-1] ? py_neg[MAG_WIDTH-1:0] : MAG_WIDTH'(py));
    end
    if (state_q == S_WAIT && mdone) begin
      case (op_dst)
        D_ACC_X: accx_q  <= res;
        D_ACC_Y: accy_q  <= res;
        D_F9X:   f9x_q   <= res;
        D_E10X:  e10x_q  <= res;
        D_F9Y:   f9y_q   <= res;
        D_E10Y:  e10y_q  <= res;
        D_T:     t_q     <= res;
        D_ETRIG: etrig_q <= res;
        D_FXT:   fxt_q   <= res;
        D_FYT:   fyt_q   <= res;
        default: t_q     <= res;
      endcase
    end
    if (state_q == S_FINISH && out_free) begin
      fx_q <= fx;
      fy_q <= fy;
      pe_q <= energy;
      te_q <= total;
      fd_q <= last_q;
    end
  end

  assign in_i.ready            = (state_q == S_IDLE);
  assign out_o.valid           = out_valid_q;
  assign out_o.force_x         = fx_q;
  assign out_o.force_y         = fy_q;
  assign out_o.particle_energy = pe_q;
  assign out_o.total_energy    = te_q;
  assign out_o.frame_done      = fd_q;

`ifndef SYNTHESIS
  a_trig_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mreq.start && op_q >= OP_T_E) |-> trig_valid)
    else $error("trig product issued before CORDIC finished");

  a_mul_idle_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ISSUE) |-> !mdone)
    else $error("multiplier done while no operation pending");

  a_frame_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH && out_free && last_q) |=> (energy_sum_q == '0))
    else $error("energy sum not cleared after last particle");

  a_result_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH && out_free) |=> (out_valid_q && in_i.ready))
    else $error("finished result not presented");
`endif

endmodule

@@ tb/sv/test_potential_force_energy_tb.sv @@
// ----------------------------------------------------------------------------
// test_potential_force_energy_tb: force and energy evaluator testbench
// Drives particle positions through the input channel, predicts forces,
// particle energy and the saturating frame sum, and checks every result beat.
// ----------------------------------------------------------------------------
module test_potential_force_energy_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PW = pfe_pkg::POS_WIDTH_DEF;
  localparam int OW = pfe_pkg::OUT_WIDTH_DEF;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [PW-1:0] x;
    logic [PW-1:0] y;
    logic          last;
  } particle_t;

  typedef struct packed {
    logic [OW-1:0] fx;
    logic [OW-1:0] fy;
    logic [OW-1:0] pe;
    logic [OW-1:0] te;
    logic          done;
  } result_t;

  logic clk_i;
  logic rst_ni;

  pfe_in_if  #(.POS_WIDTH(PW)) in_ch ();
  pfe_out_if #(.OUT_WIDTH(OW)) out_ch ();

  test_potential_force_energy #(.POS_WIDTH(PW), .OUT_WIDTH(OW)) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  particle_t   pending_q[$];
  result_t     expected_q[$];
  longint      frame_sum;
  int          mismatches;
  int          idle_cycles;
  int          cycle_no;
  int          hold_left;
  bit          timed_out;
  longint      atan_lut[18] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                                21354465, 10679838, 5340245, 2670163, 1335087,
                                667544, 333772, 166886, 83443, 41721, 20860,
                                10430, 5215};

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint rnd_shift(longint v, int k);
    return (v + (longint'(1) << (k - 1))) >>> k;
  endfunction

  function automatic longint clamp_out(longint v);
    longint hi;
    hi = (longint'(1) << (OW - 1)) - 1;
    return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
  endfunction

  task automatic cordic_turn(input longint p, output longint vc, output longint vs);
    longint ang, cr, sr, dc, ds;
    bit     neg;
    ang = longint'(p & 64'h1F_FFFF) << 11;
    if (ang >= 64'sh8000_0000) ang = ang - 64'sh1_0000_0000;
    neg = 1'b0;
    cr = 652032874;
    sr = 0;
    if (ang > 64'sh4000_0000 || ang < -64'sh4000_0000) begin
      ang = ang > 0 ? ang - 64'sh8000_0000 : ang + 64'sh8000_0000;
      neg = 1'b1;
    end
    for (int i = 0; i < 18; i++) begin
      dc = sr >>> i;
      ds = cr >>> i;
      if (ang >= 0) begin
        cr -= dc; sr += ds; ang -= atan_lut[i];
      end else begin
        cr += dc; sr -= ds; ang += atan_lut[i];
      end
    end
    vc = neg ? -cr : cr;
    vs = neg ? -sr : sr;
  endtask

  task automatic power_terms(input longint p, output longint e10, output longint f9);
    longint unsigned m, acc, t9;
    m = p < 0 ? -p : p;
    acc = m;
    for (int k = 2; k <= 9; k++) acc = (acc * m + (64'd1 << 20)) >> 21;
    t9 = (100 * acc + 16) >> 5;
    acc = (acc * m + (64'd1 << 20)) >> 21;
    e10 = longint'((10 * acc + 16) >> 5);
    f9 = p < 0 ? -longint'(t9) : longint'(t9);
  endtask

  task automatic predict_forces(input particle_t it);
    longint  px, py, ex, fxp, ey, fyp, cx, sx, cy, sy, et, ft_x, ft_y, en, tot, hi;
    result_t r;
    px = longint'($signed(it.x));
    py = longint'($signed(it.y));
    power_terms(px, ex, fxp);
    power_terms(py, ey, fyp);
    cordic_turn(px, cx, sx);
    cordic_turn(py, cy, sy);
    et = rnd_shift(5 * rnd_shift(sx * cy, 30), 14);
    ft_x = rnd_shift(rnd_shift(cx * cy, 30) * 527071785, 38);
    ft_y = rnd_shift(rnd_shift(sx * sy, 30) * 527071785, 38);
    en = clamp_out(ex + ey + et);
    hi = (longint'(1) << (OW - 1)) - 1;
    tot = clamp_out(frame_sum + en);
    if (tot > hi) tot = hi;
    r.fx = OW'(clamp_out(-(fxp + ft_x)));
    r.fy = OW'(clamp_out(ft_y - fyp));
    r.pe = OW'(en);
    r.te = OW'(tot);
    r.done = it.last;
    expected_q.insert(expected_q.size(), r);
    frame_sum = it.last ? 0 : tot;
  endtask

  function automatic logic [PW-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return {1'b1, {(PW-1){1'b0}}};
      1: return {1'b0, {(PW-1){1'b1}}};
      2, 3: return PW'($signed($urandom_range(0, 6291456)) - 3145728);
      default: return PW'($urandom);
    endcase
  endfunction

  task automatic add_particle(input logic [PW-1:0] x, input logic [PW-1:0] y,
                              input logic last);
    particle_t it;
    it.x = x;
    it.y = y;
    it.last = last;
    pending_q.insert(pending_q.size(), it);
  endtask

  initial begin
    logic [PW-1:0] xs[8];
    xs = '{{1'b1, {(PW-1){1'b0}}}, {1'b0, {(PW-1){1'b1}}}, '0, PW'(1), '1,
           PW'(2097152), PW'(1048576), PW'(-524288)};
    for (int i = 0; i < 8; i++) add_particle(xs[i], xs[(i + 3) % 8], i == 3 || i == 7);
    for (int i = 0; i < 12; i++)
      add_particle({1'b0, {(PW-1){1'b1}}}, {1'b0, {(PW-1){1'b1}}}, i == 11);
    add_particle({1'b1, {(PW-1){1'b0}}}, {1'b1, {(PW-1){1'b0}}}, 1'b1);
    for (int i = 0; i < 1550; i++)
      add_particle(pick_coord(), pick_coord(), $urandom_range(0, 7) == 0);
  end

  initial begin
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.x_pos <= '0;
      in_ch.y_pos <= '0;
      in_ch.last_particle <= 1'b0;
      frame_sum = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_forces({in_ch.x_pos, in_ch.y_pos,
                                                      in_ch.last_particle});
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_q.size() > 0 &&
            ((cycle_no > 3000 && cycle_no < 20000) || $urandom_range(0, 99) >= 8)) begin
          particle_t it;
          it = pending_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.x_pos <= it.x;
          in_ch.y_pos <= it.y;
          in_ch.last_particle <= it.last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      mismatches = 0;
      cycle_no = 0;
      idle_cycles = 0;
      hold_left = 0;
    end else begin
      cycle_no++;
      if (out_ch.valid && out_ch.ready) begin
        result_t got, exp_r;
        got = {out_ch.force_x, out_ch.force_y, out_ch.particle_energy,
               out_ch.total_energy, out_ch.frame_done};
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %p", got);
        end else begin
          exp_r = expected_q.pop_front();
          if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch exp %p got %p", exp_r, got);
          end
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (cycle_no == 1000) hold_left = 2000;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= (cycle_no > 3000 && cycle_no < 20000) || $urandom_range(0, 99) >= 8;
      end
    end
  end

  initial begin
    wait (rst_ni === 1'b1);
    wait ((pending_q.size() == 0 && !in_ch.valid && expected_q.size() == 0)
          || idle_cycles >= WATCHDOG_LIMIT);
    timed_out = idle_cycles >= WATCHDOG_LIMIT;
    if (!timed_out) repeat (200) @(posedge clk_i);
    if (timed_out || mismatches != 0 || expected_q.size() != 0) begin
      $display("simulation failed");
    end else begin
      $display("simulation ok");
    end
    $finish;
  end

endmodule
